// ----- src/crpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpt_pkg - shared types for the closest rating pair table
// Entry, cell command and reduction leaf types, operation codes and the
// depth of the radix-4 reduction tree.
// ----------------------------------------------------------------------------
package crpt_pkg;

	localparam int RATING_W = 32;
	localparam int ID_W     = 10;
	localparam int GAP_W    = 32;

	typedef enum logic [1:0] {
		MODE_JOIN  = 2'd0,
		MODE_LEAVE = 2'd1,
		MODE_QUERY = 2'd2
	} crpt_mode_t;

	// one slot of the sorted chain
	typedef struct packed {
		logic                       valid;
		logic signed [RATING_W-1:0] rating;
		logic [ID_W-1:0]            id;
	} crpt_entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic                       ins;
		logic                       rem;
		logic signed [RATING_W-1:0] key;
		logic [ID_W-1:0]            id;
		logic signed [RATING_W-1:0] cut;
	} crpt_cmd_t;

	// per-cell contribution to the reduction
	typedef struct packed {
		logic                id_hit;
		logic [RATING_W-1:0] id_rating;
		logic                rating_hit;
		logic                pair_ok;
		logic [GAP_W-1:0]    gap;
		logic [ID_W-1:0]     hi_id;
		logic [ID_W-1:0]     lo_id;
	} crpt_leaf_t;

	// number of radix-4 levels covering n leaves
	function automatic int crpt_levels(input int n);
		int lv;
		int span;
		lv   = 1;
		span = 4;
		while (span < n) begin
			span = span * 4;
			lv   = lv + 1;
		end
		return lv;
	endfunction

endpackage

// ----- src/crpt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpt_cell - one slot of the sorted chain
// Holds one member, shifts right on an insert below it, shifts left on a
// removal at or below it, and produces its leaf for the reduction tree.
// ----------------------------------------------------------------------------
module crpt_cell
	import crpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  crpt_cmd_t   cmd,
	input  crpt_entry_t left,
	input  logic        left_gt,
	input  crpt_entry_t right,
	output crpt_entry_t self,
	output logic        gt,
	output crpt_leaf_t  leaf
);

	logic                       valid_q;
	logic signed [RATING_W-1:0] rating_q;
	logic [ID_W-1:0]            id_q;
	crpt_entry_t                nxt;
	logic                       take;
	logic [RATING_W:0]          diff;

	assign self = '{valid: valid_q, rating: rating_q, id: id_q};
	// empty slots count as above any key
	assign gt   = !valid_q || (rating_q > cmd.key);

	always_comb begin
		nxt  = self;
		take = 1'b0;
		if (cmd.ins && gt) begin
			take = 1'b1;
			if (left_gt) begin
				nxt = left;
			end else begin
				nxt = '{valid: 1'b1, rating: cmd.key, id: cmd.id};
			end
		end else if (cmd.rem && valid_q && (rating_q >= cmd.cut)) begin
			take = 1'b1;
			nxt  = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rating_q <= nxt.rating;
			id_q     <= nxt.id;
		end
	end

	assign diff = {rating_q[RATING_W-1], rating_q} - {left.rating[RATING_W-1], left.rating};

	always_comb begin
		leaf.id_hit     = valid_q && (id_q == cmd.id);
		leaf.id_rating  = leaf.id_hit ? rating_q : '0;
		leaf.rating_hit = valid_q && (rating_q == cmd.key);
		leaf.pair_ok    = valid_q && left.valid;
		leaf.gap        = diff[GAP_W-1:0];
		leaf.hi_id      = id_q;
		leaf.lo_id      = left.id;
	end

endmodule

// ----- src/crpt_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crpt_tree - registered radix-4 reduction over the cell leaves
// ORs the lookup hits and keeps the smallest adjacent gap, later pair on a
// tie. One register level per radix-4 level.
// ----------------------------------------------------------------------------
module crpt_tree
	import crpt_pkg::*;
#(
	parameter int N = 1024
) (
	input  logic       clk,
	input  crpt_leaf_t leaf [N],
	output crpt_leaf_t root
);

	localparam int LEVELS = crpt_levels(N);
	localparam int LEAVES = 4 ** LEVELS;
	localparam int NODES  = (LEAVES - 1) / 3;

	function automatic int lvl_off(input int l);
		int acc;
		acc = 0;
		for (int k = 0; k < l; k++) begin
			acc = acc + (LEAVES >> (2 * (k + 1)));
		end
		return acc;
	endfunction

	// a is the lower-index side
	function automatic crpt_leaf_t comb2(input crpt_leaf_t a, input crpt_leaf_t b);
		crpt_leaf_t r;
		r            = a;
		if (b.pair_ok && (!a.pair_ok || (b.gap <= a.gap))) begin
			r = b;
		end
		r.id_hit     = a.id_hit | b.id_hit;
		r.id_rating  = a.id_rating | b.id_rating;
		r.rating_hit = a.rating_hit | b.rating_hit;
		return r;
	endfunction

	crpt_leaf_t pad [LEAVES];
	crpt_leaf_t node_q [NODES];

	for (genvar i = 0; i < LEAVES; i++) begin : g_pad
		if (i < N) begin : g_real
			assign pad[i] = leaf[i];
		end else begin : g_zero
			assign pad[i] = '0;
		end
	end

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		localparam int NOUT = LEAVES >> (2 * (l + 1));
		localparam int OFF  = lvl_off(l);
		for (genvar j = 0; j < NOUT; j++) begin : g_node
			if (l == 0) begin : g_first
				always_ff @(posedge clk) begin
					node_q[OFF + j] <= comb2(comb2(pad[4*j], pad[4*j+1]),
						comb2(pad[4*j+2], pad[4*j+3]));
				end
			end else begin : g_upper
				localparam int SRC = lvl_off(l - 1) + 4 * j;
				always_ff @(posedge clk) begin
					node_q[OFF + j] <= comb2(comb2(node_q[SRC], node_q[SRC+1]),
						comb2(node_q[SRC+2], node_q[SRC+3]));
				end
			end
		end
	end

	assign root = node_q[NODES-1];

endmodule

// ----- src/closest_rating_pair_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_rating_pair_table - sorted member set with closest-pair query
// Chain of cells sorted by rating, plus a registered reduction tree.
// ----------------------------------------------------------------------------
// Use:
//  - Items enter on the s_ stream: tuser carries the operation (join, leave,
//    query, or an unused code that is dropped), tdata the id and rating.
//  - Only a query produces a result item on the m_ stream: found flag and
//    the ids of the closest pair, higher-rated member first.
//  - One item is in flight at a time. Each item is accepted, passes the
//    LEVELS = ceil(log4(MAX_MEMBERS)) register levels of the radix-4
//    reduction tree that does the id/rating lookup and the minimum-gap
//    search, and then updates the chain or loads the result. The unused
//    code is dropped when it is accepted.
//  - The chain itself shifts a whole insert or removal at once, in all cells together.
//  - The result sits in an output register, so the next item is accepted
//    while it waits. A query that finishes while the previous result is
//    still held waits in its final cycle until the receiver takes it.
//  - Reset empties the table (cell valid bits and count cleared) and drops
//    any pending result. No clearing pass is needed.
//  - Duplicate ids or ratings, joins into a full table and leaves of absent
//    ids are silently ignored.
// ----------------------------------------------------------------------------
module closest_rating_pair_table
	import crpt_pkg::*;
#(
	parameter int MAX_MEMBERS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [9:0] member_id, [41:10] rating, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [0] found, [10:1] higher_id, [20:11] lower_id
);

	localparam int LEVELS = crpt_levels(MAX_MEMBERS);
	localparam int WCNT_W = $clog2(LEVELS + 1);
	localparam int CNT_W  = $clog2(MAX_MEMBERS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_APPLY
	} state_t;

	state_t                     state_q;
	logic [WCNT_W-1:0]          wait_q;
	logic [CNT_W-1:0]           count_q;
	crpt_mode_t                 mode_q;
	logic [ID_W-1:0]            id_q;
	logic signed [RATING_W-1:0] rating_q;
	logic                       m_tvalid_q;
	logic [23:0]                m_tdata_q;

	crpt_cmd_t   cmd;
	crpt_leaf_t  root;
	crpt_entry_t ent [MAX_MEMBERS];
	logic        gt [MAX_MEMBERS];
	crpt_leaf_t  leaf [MAX_MEMBERS];
	logic        s_acc;
	logic        found;
	logic        load_res;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign found    = (count_q >= CNT_W'(2));
	// query result goes into the output register this cycle
	assign load_res = (state_q == ST_APPLY) && (mode_q == MODE_QUERY)
		&& (!m_tvalid_q || m_tready);

	// broadcast to the chain; ins/rem only fire in the apply cycle
	always_comb begin
		cmd.key = rating_q;
		cmd.id  = id_q;
		cmd.cut = root.id_rating;
		cmd.ins = (state_q == ST_APPLY) && (mode_q == MODE_JOIN) && !root.id_hit
			&& !root.rating_hit && (count_q != CNT_W'(MAX_MEMBERS));
		cmd.rem = (state_q == ST_APPLY) && (mode_q == MODE_LEAVE) && root.id_hit;
	end

	// sorted chain, lowest rating in cell 0, members packed from cell 0 up
	for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_cell
		crpt_entry_t l_ent;
		crpt_entry_t r_ent;
		logic        l_gt;
		if (i == 0) begin : g_head
			assign l_ent = '0;
			assign l_gt  = 1'b0;
		end else begin : g_mid
			assign l_ent = ent[i-1];
			assign l_gt  = gt[i-1];
		end
		if (i == MAX_MEMBERS - 1) begin : g_tail
			assign r_ent = '0;
		end else begin : g_inner
			assign r_ent = ent[i+1];
		end
		crpt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.left    (l_ent),
			.left_gt (l_gt),
			.right   (r_ent),
			.self    (ent[i]),
			.gt      (gt[i]),
			.leaf    (leaf[i])
		);
	end

	crpt_tree #(
		.N (MAX_MEMBERS)
	) u_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wait_q     <= '0;
			count_q    <= '0;
			mode_q     <= MODE_JOIN;
			id_q       <= '0;
			rating_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !load_res) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						mode_q   <= crpt_mode_t'(s_tuser);
						id_q     <= s_tdata[ID_W-1:0];
						rating_q <= s_tdata[ID_W+RATING_W-1:ID_W];
						wait_q   <= '0;
						case (s_tuser)
							MODE_JOIN, MODE_LEAVE, MODE_QUERY: state_q <= ST_WAIT;
							default:                           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WAIT: begin
					// root is valid once the item has passed every register level of the tree
					if (wait_q == WCNT_W'(LEVELS - 1)) begin
						state_q <= ST_APPLY;
					end else begin
						wait_q <= wait_q + WCNT_W'(1);
					end
				end
				ST_APPLY: begin
					unique case (mode_q)
						MODE_JOIN: begin
							if (cmd.ins) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= ST_IDLE;
						end
						MODE_LEAVE: begin
							if (cmd.rem) begin
								count_q <= count_q - CNT_W'(1);
							end
							state_q <= ST_IDLE;
						end
						MODE_QUERY: begin
							if (load_res) begin
								m_tvalid_q <= 1'b1;
								m_tdata_q  <= {3'b000,
									found ? root.lo_id : {ID_W{1'b0}},
									found ? root.hi_id : {ID_W{1'b0}},
									found};
								state_q    <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- checks ----
	logic [MAX_MEMBERS-1:0] vld_vec;
	logic [MAX_MEMBERS-1:0] vld_inc;

	for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_vld
		assign vld_vec[i] = ent[i].valid;
	end
	assign vld_inc = vld_vec + MAX_MEMBERS'(1);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_MEMBERS))
		else $error("member count above table size");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(count_q))
		else $error("occupied cells disagree with member count");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_inc & vld_vec) == '0)
		else $error("occupied cells not packed from the head");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_APPLY && mode_q == MODE_QUERY))
		else $error("result raised outside a query");

endmodule
